/* rtl/core/uscal_pkg.sv */
package uscal_pkg;

   // Pipeline depth, one register rank per stage
   localparam int NUM_STAGES = 6;

   localparam int SECS_W   = 32;
   localparam int DAYS_W   = 16;
   localparam int TOD_W    = 17;
   localparam int DOY_W    = 9;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int MDAY_W   = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   // 86400 = 128 * 675; floor(q / 675) = (q * DAY_RECIP) >> DAY_SHIFT for q < 2^25
   localparam logic [25:0] DAY_RECIP = 26'd50903317;
   localparam int          DAY_SHIFT = 35;
   localparam logic [9:0]  DAY_ODD   = 10'd675;

   // floor(d / 1461) = (d * CYC_RECIP) >> CYC_SHIFT for d < 2^16
   localparam logic [16:0] CYC_RECIP = 17'd91868;
   localparam int          CYC_SHIFT = 27;
   localparam logic [10:0] CYC_DAYS  = 11'd1461;

   // floor(x / 15) = (x * FIF_RECIP) >> FIF_SHIFT for x < 21600
   localparam logic [14:0] FIF_RECIP = 15'd17477;
   localparam int          FIF_SHIFT = 18;

   // First day of 2100-03-01 counted from 1970-01-01; a phantom Feb 29 is
   // inserted there so plain four-year cycles hold across the whole range
   localparam logic [DAYS_W-1:0] SKIP_2100 = 16'd47541;
   // Days from 1968-01-01 (leap year heading a cycle) to 1970-01-01
   localparam logic [DAYS_W-1:0] EPOCH_OFS = 16'd731;
   localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1968;

   // Day of year on which month idx (0 = January) starts
   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] idx, input logic leap);
      logic [DOY_W-1:0] s;
      case (idx)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd59;
         4'd3:    s = 9'd90;
         4'd4:    s = 9'd120;
         4'd5:    s = 9'd151;
         4'd6:    s = 9'd181;
         4'd7:    s = 9'd212;
         4'd8:    s = 9'd243;
         4'd9:    s = 9'd273;
         4'd10:   s = 9'd304;
         4'd11:   s = 9'd334;
         default: s = 9'd0;
      endcase
      if (leap && idx >= 4'd2) begin
         s = s + 9'd1;
      end
      return s;
   endfunction

endpackage

/* rtl/core/uscal_split.sv */
// Stages 0 and 1: split seconds into whole days and seconds of day.
module uscal_split (
   input  logic                                  clock,
   input  logic [uscal_pkg::NUM_STAGES-1:0]      stage_en,
   input  logic [uscal_pkg::SECS_W-1:0]          unix_seconds,
   output logic [uscal_pkg::DAYS_W-1:0]          days,
   output logic [uscal_pkg::TOD_W-1:0]           tod
);

   logic [24:0]                     quot_ff;
   logic [6:0]                      low_ff;
   logic [50:0]                     prod_ff;
   logic [50:0]                     prod_in;
   logic [uscal_pkg::DAYS_W-1:0]    days_ff;
   logic [uscal_pkg::DAYS_W-1:0]    days_in;
   logic [uscal_pkg::TOD_W-1:0]     tod_ff;
   logic [uscal_pkg::TOD_W-1:0]     tod_in;
   logic [uscal_pkg::DAYS_W-1:0]    day_raw;
   logic [25:0]                     rem_full;

   assign prod_in = 51'(unix_seconds[31:7]) * 51'(uscal_pkg::DAY_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         quot_ff <= unix_seconds[31:7];
         low_ff  <= unix_seconds[6:0];
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      day_raw  = prod_ff[uscal_pkg::DAY_SHIFT +: uscal_pkg::DAYS_W];
      rem_full = 26'(quot_ff) - 26'(day_raw) * 26'(uscal_pkg::DAY_ODD);
      tod_in   = {rem_full[9:0], low_ff};
      // add the phantom leap day of 2100
      days_in  = (day_raw >= uscal_pkg::SKIP_2100) ? day_raw + 16'd1 : day_raw;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
   end

   assign days = days_ff;
   assign tod  = tod_ff;

endmodule

/* rtl/core/uscal_date.sv */
// Stages 2 to 5: day count to year, month and day of month.
module uscal_date (
   input  logic                                  clock,
   input  logic [uscal_pkg::NUM_STAGES-1:0]      stage_en,
   input  logic [uscal_pkg::DAYS_W-1:0]          days,
   output logic [uscal_pkg::YEAR_W-1:0]          year,
   output logic [uscal_pkg::MONTH_W-1:0]         month,
   output logic [uscal_pkg::MDAY_W-1:0]          day_of_month
);

   logic [uscal_pkg::DAYS_W-1:0]    d2_ff;
   logic [uscal_pkg::DAYS_W-1:0]    d2_in;
   logic [32:0]                     pc_ff;
   logic [32:0]                     pc_in;
   logic [5:0]                      cyc_ff;
   logic [5:0]                      cyc_in;
   logic [10:0]                     rcyc_ff;
   logic [10:0]                     rcyc_in;
   logic [uscal_pkg::YEAR_W-1:0]    year_ff;
   logic [uscal_pkg::YEAR_W-1:0]    year_in;
   logic [uscal_pkg::DOY_W-1:0]     doy_ff;
   logic [uscal_pkg::DOY_W-1:0]     doy_in;
   logic                            leap_ff;
   logic                            leap_in;
   logic [uscal_pkg::YEAR_W-1:0]    yout_ff;
   logic [uscal_pkg::MONTH_W-1:0]   month_ff;
   logic [uscal_pkg::MONTH_W-1:0]   month_in;
   logic [uscal_pkg::MDAY_W-1:0]    mday_ff;
   logic [uscal_pkg::MDAY_W-1:0]    mday_in;
   logic [16:0]                     rcyc_full;
   logic [1:0]                      yoff;
   logic [10:0]                     doy_wide;
   logic [3:0]                      midx;
   logic [uscal_pkg::DOY_W-1:0]     mstart;

   // stage 2: rebase to 1968 and multiply by the cycle reciprocal
   always_comb begin
      d2_in = days + uscal_pkg::EPOCH_OFS;
      pc_in = 33'(d2_in) * 33'(uscal_pkg::CYC_RECIP);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         d2_ff <= d2_in;
         pc_ff <= pc_in;
      end
   end

   // stage 3: cycle number and day within the cycle
   always_comb begin
      cyc_in    = pc_ff[uscal_pkg::CYC_SHIFT +: 6];
      rcyc_full = 17'(d2_ff) - 17'(cyc_in) * 17'(uscal_pkg::CYC_DAYS);
      rcyc_in   = rcyc_full[10:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         cyc_ff  <= cyc_in;
         rcyc_ff <= rcyc_in;
      end
   end

   // stage 4: year within the cycle; the first year of each cycle is leap
   always_comb begin
      if (rcyc_ff < 11'd366) begin
         yoff     = 2'd0;
         doy_wide = rcyc_ff;
      end else if (rcyc_ff < 11'd731) begin
         yoff     = 2'd1;
         doy_wide = rcyc_ff - 11'd366;
      end else if (rcyc_ff < 11'd1096) begin
         yoff     = 2'd2;
         doy_wide = rcyc_ff - 11'd731;
      end else begin
         yoff     = 2'd3;
         doy_wide = rcyc_ff - 11'd1096;
      end
      doy_in  = doy_wide[uscal_pkg::DOY_W-1:0];
      leap_in = (yoff == 2'd0);
      year_in = uscal_pkg::BASE_YEAR + {4'd0, cyc_ff, 2'b00} + {10'd0, yoff};
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         year_ff <= year_in;
         doy_ff  <= doy_in;
         leap_ff <= leap_in;
      end
   end

   // stage 5: count the month starts already passed
   always_comb begin
      midx = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy_ff >= uscal_pkg::month_start(4'(m), leap_ff)) begin
            midx = midx + 4'd1;
         end
      end
      mstart   = uscal_pkg::month_start(midx, leap_ff);
      month_in = midx + 4'd1;
      mday_in  = 5'(doy_ff - mstart) + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         yout_ff  <= year_ff;
         month_ff <= month_in;
         mday_ff  <= mday_in;
      end
   end

   assign year         = yout_ff;
   assign month        = month_ff;
   assign day_of_month = mday_ff;

endmodule

/* rtl/core/uscal_clock.sv */
// Stages 2 to 5: seconds of day to hour, minute and second.
module uscal_clock (
   input  logic                                  clock,
   input  logic [uscal_pkg::NUM_STAGES-1:0]      stage_en,
   input  logic [uscal_pkg::TOD_W-1:0]           tod,
   output logic [uscal_pkg::HOUR_W-1:0]          hour,
   output logic [uscal_pkg::MINUTE_W-1:0]        minute,
   output logic [uscal_pkg::SECOND_W-1:0]        second
);

   logic [uscal_pkg::TOD_W-1:0]      tod_ff;
   logic [29:0]                      pm_ff;
   logic [29:0]                      pm_in;
   logic [10:0]                      mins_ff;
   logic [10:0]                      mins_in;
   logic [uscal_pkg::SECOND_W-1:0]   sec_ff;
   logic [uscal_pkg::SECOND_W-1:0]   sec_in;
   logic [23:0]                      ph_ff;
   logic [23:0]                      ph_in;
   logic [10:0]                      mins2_ff;
   logic [uscal_pkg::SECOND_W-1:0]   sec2_ff;
   logic [uscal_pkg::HOUR_W-1:0]     hour_ff;
   logic [uscal_pkg::HOUR_W-1:0]     hour_in;
   logic [uscal_pkg::MINUTE_W-1:0]   minute_ff;
   logic [uscal_pkg::MINUTE_W-1:0]   minute_in;
   logic [uscal_pkg::SECOND_W-1:0]   sec3_ff;
   logic [uscal_pkg::TOD_W-1:0]      sec_full;
   logic [10:0]                      min_full;

   // stage 2: minutes of day = (tod / 4) / 15
   assign pm_in = 30'(tod[16:2]) * 30'(uscal_pkg::FIF_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         tod_ff <= tod;
         pm_ff  <= pm_in;
      end
   end

   // stage 3
   always_comb begin
      mins_in  = pm_ff[uscal_pkg::FIF_SHIFT +: 11];
      sec_full = tod_ff - 17'(mins_in) * 17'd60;
      sec_in   = sec_full[uscal_pkg::SECOND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         mins_ff <= mins_in;
         sec_ff  <= sec_in;
      end
   end

   // stage 4: hour = (minutes / 4) / 15
   assign ph_in = 24'(mins_ff[10:2]) * 24'(uscal_pkg::FIF_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         ph_ff    <= ph_in;
         mins2_ff <= mins_ff;
         sec2_ff  <= sec_ff;
      end
   end

   // stage 5
   always_comb begin
      hour_in   = ph_ff[uscal_pkg::FIF_SHIFT +: uscal_pkg::HOUR_W];
      min_full  = mins2_ff - 11'(hour_in) * 11'd60;
      minute_in = min_full[uscal_pkg::MINUTE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         sec3_ff   <= sec2_ff;
      end
   end

   assign hour   = hour_ff;
   assign minute = minute_ff;
   assign second = sec3_ff;

endmodule

/* rtl/core/unix_seconds_to_calendar_time_core.sv */
// Channel  Direction  Payload
// req      in         tdata[31:0]  unix_seconds
// rsp      out        tdata[39:0]  year, month, day_of_month, hour, minute, second
//
// Six register stages; a request enters each cycle unless a stalled response
// backs up to stage 0. The day and cycle reciprocal multiplies set the depth.
// Reset clears the stage valid bits only.
// A stalled response holds its stage; empty stages ahead of a stall still
// fill, so bubbles close up without losing or repeating a request.
module unix_seconds_to_calendar_time_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] unix_seconds
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata    // [11:0] year, [15:12] month, [20:16] day_of_month,
                                      // [25:21] hour, [31:26] minute, [37:32] second
);

   localparam int NS = uscal_pkg::NUM_STAGES;

   logic [NS-1:0]                       valid_ff;
   logic [NS-1:0]                       valid_in;
   logic [NS-1:0]                       stage_en;
   logic [uscal_pkg::DAYS_W-1:0]        days;
   logic [uscal_pkg::TOD_W-1:0]         tod;
   logic [uscal_pkg::YEAR_W-1:0]        year;
   logic [uscal_pkg::MONTH_W-1:0]       month;
   logic [uscal_pkg::MDAY_W-1:0]        day_of_month;
   logic [uscal_pkg::HOUR_W-1:0]        hour;
   logic [uscal_pkg::MINUTE_W-1:0]      minute;
   logic [uscal_pkg::SECOND_W-1:0]      second;

   // advance a stage when it is empty or the next one advances
   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      for (int i = 0; i < NS; i++) begin
         if (stage_en[i]) begin
            valid_in[i] = (i == 0) ? req_tvalid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   uscal_split u_split (
      .clock        (clock),
      .stage_en     (stage_en),
      .unix_seconds (req_tdata),
      .days         (days),
      .tod          (tod)
   );

   uscal_date u_date (
      .clock        (clock),
      .stage_en     (stage_en),
      .days         (days),
      .year         (year),
      .month        (month),
      .day_of_month (day_of_month)
   );

   uscal_clock u_clock (
      .clock    (clock),
      .stage_en (stage_en),
      .tod      (tod),
      .hour     (hour),
      .minute   (minute),
      .second   (second)
   );

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = {2'b00, second, minute, hour, day_of_month, month, year};

endmodule
